### rtl/ethtcp_pkg.sv
`default_nettype none

package ethtcp_pkg;

   localparam int unsigned DEFAULT_MAX_FRAME_BYTES = 65535;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned MAC_W    = 48;
   localparam int unsigned ETYPE_W  = 16;
   localparam int unsigned IP_W     = 32;
   localparam int unsigned PORT_W   = 16;
   localparam int unsigned LEN_W    = 16;
   localparam int unsigned WORDS_W  = 4;
   localparam int unsigned STATUS_W = 2;

   localparam logic [LEN_W-1:0] ETH_LEN = LEN_W'(14);
   localparam logic [LEN_W-1:0] MIN_HDR = LEN_W'(5 * 4);

   localparam logic [LEN_W-1:0] SRC_IP_FIRST = ETH_LEN + LEN_W'(12);
   localparam logic [LEN_W-1:0] DST_IP_FIRST = ETH_LEN + LEN_W'(16);
   localparam logic [LEN_W-1:0] IP_ADDR_END  = ETH_LEN + LEN_W'(20);
   localparam logic [LEN_W-1:0] TCP_OFFS_POS = LEN_W'(12);

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ETH_SHORT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_IP_SHORT  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_TCP_SHORT = 2'd3;

   typedef struct packed {
      logic [MAC_W-1:0]   dst_mac;
      logic [MAC_W-1:0]   src_mac;
      logic [ETYPE_W-1:0] ether_type;
      logic [IP_W-1:0]    src_ip;
      logic [IP_W-1:0]    dst_ip;
      logic [PORT_W-1:0]  sport;
      logic [PORT_W-1:0]  dport;
      logic [WORDS_W-1:0] ip_words;
      logic [WORDS_W-1:0] tcp_words;
      logic [LEN_W-1:0]   count;
   } frame_rec_type;

   typedef struct packed {
      logic          valid;
      frame_rec_type rec;
   } frame_xfer_type;

endpackage

`default_nettype wire

### rtl/ethtcp_channels.sv
`default_nettype none

interface ethtcp_req_if;
   import ethtcp_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] frame_byte;
   logic              last_byte;

   modport source (output valid, output frame_byte, output last_byte, input ready);
   modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface ethtcp_rsp_if;
   import ethtcp_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [MAC_W-1:0]    dst_mac;
   logic [MAC_W-1:0]    src_mac;
   logic [ETYPE_W-1:0]  ether_type;
   logic [IP_W-1:0]     src_ip;
   logic [IP_W-1:0]     dst_ip;
   logic [PORT_W-1:0]   sport;
   logic [PORT_W-1:0]   dport;
   logic [LEN_W-1:0]    payload_length;
   logic [LEN_W-1:0]    captured_length;

   modport source (
      output valid, output status, output dst_mac, output src_mac, output ether_type,
      output src_ip, output dst_ip, output sport, output dport,
      output payload_length, output captured_length, input ready
   );
   modport sink (
      input valid, input status, input dst_mac, input src_mac, input ether_type,
      input src_ip, input dst_ip, input sport, input dport,
      input payload_length, input captured_length, output ready
   );
endinterface

`default_nettype wire

### rtl/eth_ipv4_tcp_header_extractor_top.sv
`default_nettype none

// Ethernet/IPv4/TCP header extractor. Takes a frame one byte per cycle on req_chan while
// req_chan.ready is high, last_byte marking its end, and returns one item per frame on
// rsp_chan with the MAC addresses, EtherType, IPv4 addresses, TCP ports, captured length,
// payload length and a status (parsed, Ethernet short, IPv4 header short, TCP header
// short). Bytes are taken back to back at one per cycle while ready holds, any frame
// length down to one byte included. A frame's fields enter a two-entry frame queue when
// its last byte is accepted and pass on to the result register; req_chan.ready falls only
// when two finished frames wait behind a stalled rsp_chan. Bytes beyond MAX_FRAME_BYTES are
// neither counted nor captured, though their last mark still closes the frame.
module eth_ipv4_tcp_header_extractor_top #(
   parameter int unsigned MAX_FRAME_BYTES = ethtcp_pkg::DEFAULT_MAX_FRAME_BYTES
) (
   input wire logic      clock,
   input wire logic      reset,
   ethtcp_req_if.sink    req_chan,
   ethtcp_rsp_if.source  rsp_chan
);
   import ethtcp_pkg::*;

   frame_xfer_type push;
   frame_xfer_type head;
   logic           push_ready;
   logic           pop;

   ethtcp_front #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_ready (push_ready),
      .push       (push)
   );

   ethtcp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .head       (head),
      .pop        (pop)
   );

   ethtcp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

### rtl/ethtcp_front.sv
`default_nettype none

module ethtcp_front #(
   parameter int unsigned MAX_FRAME_BYTES = ethtcp_pkg::DEFAULT_MAX_FRAME_BYTES
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   ethtcp_req_if.sink                       req_chan,
   input  wire logic                        push_ready,
   output ethtcp_pkg::frame_xfer_type       push
);
   import ethtcp_pkg::*;

   localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 1);

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [WORDS_W-1:0] ip_words_ff, ip_words_in;
   logic [WORDS_W-1:0] tcp_words_ff, tcp_words_in;
   logic [MAC_W-1:0]   dst_mac_ff, dst_mac_in;
   logic [MAC_W-1:0]   src_mac_ff, src_mac_in;
   logic [ETYPE_W-1:0] ether_type_ff, ether_type_in;
   logic [IP_W-1:0]    src_ip_ff, src_ip_in;
   logic [IP_W-1:0]    dst_ip_ff, dst_ip_in;
   logic [PORT_W-1:0]  sport_ff, sport_in;
   logic [PORT_W-1:0]  dport_ff, dport_in;

   logic               accept;
   logic               in_range;
   logic [BYTE_W-1:0]  b;
   logic [LEN_W-1:0]   pos;
   logic [WORDS_W-1:0] ip_eff;
   logic [LEN_W-1:0]   tcp_start;
   logic [LEN_W-1:0]   tcp_off;
   logic               past_tcp;
   frame_rec_type      rec;

   assign req_chan.ready = push_ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign b              = req_chan.frame_byte;
   assign pos            = LEN_W'(pos_ff);
   assign in_range       = pos_ff < POS_W'(MAX_FRAME_BYTES);

   // IHL written by this byte already moves the TCP start
   assign ip_eff    = (pos == ETH_LEN) ? b[WORDS_W-1:0] : ip_words_ff;
   assign tcp_start = ETH_LEN + {{(LEN_W-WORDS_W-2){1'b0}}, ip_eff, 2'b00};
   assign past_tcp  = pos >= tcp_start;
   assign tcp_off   = pos - tcp_start;

   always_comb begin
      pos_in        = pos_ff;
      ip_words_in   = ip_words_ff;
      tcp_words_in  = tcp_words_ff;
      dst_mac_in    = dst_mac_ff;
      src_mac_in    = src_mac_ff;
      ether_type_in = ether_type_ff;
      src_ip_in     = src_ip_ff;
      dst_ip_in     = dst_ip_ff;
      sport_in      = sport_ff;
      dport_in      = dport_ff;

      if (accept && in_range) begin
         pos_in = pos_ff + POS_W'(1);
         if (pos < LEN_W'(6)) begin
            dst_mac_in = {dst_mac_ff[MAC_W-BYTE_W-1:0], b};
         end else if (pos < LEN_W'(12)) begin
            src_mac_in = {src_mac_ff[MAC_W-BYTE_W-1:0], b};
         end else if (pos < ETH_LEN) begin
            ether_type_in = {ether_type_ff[ETYPE_W-BYTE_W-1:0], b};
         end
         ip_words_in = ip_eff;
         if (pos >= SRC_IP_FIRST && pos < DST_IP_FIRST) begin
            src_ip_in = {src_ip_ff[IP_W-BYTE_W-1:0], b};
         end
         if (pos >= DST_IP_FIRST && pos < IP_ADDR_END) begin
            dst_ip_in = {dst_ip_ff[IP_W-BYTE_W-1:0], b};
         end
         if (past_tcp && tcp_off < LEN_W'(2)) begin
            sport_in = {sport_ff[PORT_W-BYTE_W-1:0], b};
         end
         if (past_tcp && tcp_off >= LEN_W'(2) && tcp_off < LEN_W'(4)) begin
            dport_in = {dport_ff[PORT_W-BYTE_W-1:0], b};
         end
         if (past_tcp && tcp_off == TCP_OFFS_POS) begin
            tcp_words_in = b[BYTE_W-1:BYTE_W-WORDS_W];
         end
      end

      rec.dst_mac    = dst_mac_in;
      rec.src_mac    = src_mac_in;
      rec.ether_type = ether_type_in;
      rec.src_ip     = src_ip_in;
      rec.dst_ip     = dst_ip_in;
      rec.sport      = sport_in;
      rec.dport      = dport_in;
      rec.ip_words   = ip_words_in;
      rec.tcp_words  = tcp_words_in;
      rec.count      = LEN_W'(pos_in);

      push.valid = accept && req_chan.last_byte;
      push.rec   = rec;
   end

   always_ff @(posedge clock) begin
      if (reset || push.valid) begin
         pos_ff        <= '0;
         ip_words_ff   <= '0;
         tcp_words_ff  <= '0;
         dst_mac_ff    <= '0;
         src_mac_ff    <= '0;
         ether_type_ff <= '0;
         src_ip_ff     <= '0;
         dst_ip_ff     <= '0;
         sport_ff      <= '0;
         dport_ff      <= '0;
      end else begin
         pos_ff        <= pos_in;
         ip_words_ff   <= ip_words_in;
         tcp_words_ff  <= tcp_words_in;
         dst_mac_ff    <= dst_mac_in;
         src_mac_ff    <= src_mac_in;
         ether_type_ff <= ether_type_in;
         src_ip_ff     <= src_ip_in;
         dst_ip_ff     <= dst_ip_in;
         sport_ff      <= sport_in;
         dport_ff      <= dport_in;
      end
   end

endmodule

`default_nettype wire

### rtl/ethtcp_queue.sv
`default_nettype none

module ethtcp_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  ethtcp_pkg::frame_xfer_type push,
   output logic                       push_ready,
   output ethtcp_pkg::frame_xfer_type head,
   input  wire logic                  pop
);
   import ethtcp_pkg::*;

   frame_rec_type entry_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    fill_ff, fill_in;
   logic          do_push, do_pop;

   assign push_ready = fill_ff != 2'd2;
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop && (fill_ff != 2'd0);

   assign head.valid = fill_ff != 2'd0;
   assign head.rec   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.rec;
      end
   end

endmodule

`default_nettype wire

### rtl/ethtcp_back.sv
`default_nettype none

module ethtcp_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  ethtcp_pkg::frame_xfer_type head,
   output logic                       pop,
   ethtcp_rsp_if.source               rsp_chan
);
   import ethtcp_pkg::*;

   logic                valid_ff, valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [LEN_W-1:0]    payload_ff, payload_in;
   frame_rec_type       rec_ff;

   logic [LEN_W-1:0] ip_len, tcp_len, left_ip, left_tcp;

   assign pop = head.valid && (!valid_ff || rsp_chan.ready);

   assign ip_len   = {{(LEN_W-WORDS_W-2){1'b0}}, head.rec.ip_words, 2'b00};
   assign tcp_len  = {{(LEN_W-WORDS_W-2){1'b0}}, head.rec.tcp_words, 2'b00};
   assign left_ip  = head.rec.count - ETH_LEN;
   assign left_tcp = left_ip - ip_len;

   always_comb begin
      status_in  = STATUS_OK;
      payload_in = '0;
      if (head.rec.count < ETH_LEN) begin
         status_in = STATUS_ETH_SHORT;
      end else if (left_ip < MIN_HDR || left_ip < ip_len) begin
         status_in = STATUS_IP_SHORT;
      end else if (left_tcp < MIN_HDR || left_tcp < tcp_len) begin
         status_in = STATUS_TCP_SHORT;
      end else begin
         payload_in = left_tcp - tcp_len;
      end

      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         status_ff  <= status_in;
         payload_ff <= payload_in;
         rec_ff     <= head.rec;
      end
   end

   assign rsp_chan.valid           = valid_ff;
   assign rsp_chan.status          = status_ff;
   assign rsp_chan.dst_mac         = rec_ff.dst_mac;
   assign rsp_chan.src_mac         = rec_ff.src_mac;
   assign rsp_chan.ether_type      = rec_ff.ether_type;
   assign rsp_chan.src_ip          = rec_ff.src_ip;
   assign rsp_chan.dst_ip          = rec_ff.dst_ip;
   assign rsp_chan.sport           = rec_ff.sport;
   assign rsp_chan.dport           = rec_ff.dport;
   assign rsp_chan.payload_length  = payload_ff;
   assign rsp_chan.captured_length = rec_ff.count;

endmodule

`default_nettype wire

### tb/sv/ethtcp_tb_pkg.sv
`default_nettype none

package ethtcp_tb_pkg;
   import ethtcp_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [MAC_W-1:0]    dst_mac;
      logic [MAC_W-1:0]    src_mac;
      logic [ETYPE_W-1:0]  ether_type;
      logic [IP_W-1:0]     src_ip;
      logic [IP_W-1:0]     dst_ip;
      logic [PORT_W-1:0]   sport;
      logic [PORT_W-1:0]   dport;
      logic [LEN_W-1:0]    payload_length;
      logic [LEN_W-1:0]    captured_length;
   } hdr_result_type;

   class frame_scoreboard;
      int unsigned        max_bytes;
      int unsigned        byte_pos;
      logic [WORDS_W-1:0] ip_words;
      logic [WORDS_W-1:0] tcp_words;
      logic [MAC_W-1:0]   dst_mac;
      logic [MAC_W-1:0]   src_mac;
      logic [ETYPE_W-1:0] ether_type;
      logic [IP_W-1:0]    src_ip;
      logic [IP_W-1:0]    dst_ip;
      logic [PORT_W-1:0]  sport;
      logic [PORT_W-1:0]  dport;
      hdr_result_type     pending[$];
      int unsigned        errors;
      int unsigned        checked;

      function new(int unsigned max_frame_bytes);
         max_bytes = max_frame_bytes;
         errors    = 0;
         checked   = 0;
         clear();
      endfunction

      function void clear();
         byte_pos   = 0;
         ip_words   = '0;
         tcp_words  = '0;
         dst_mac    = '0;
         src_mac    = '0;
         ether_type = '0;
         src_ip     = '0;
         dst_ip     = '0;
         sport      = '0;
         dport      = '0;
      endfunction

      function void note_byte(logic [BYTE_W-1:0] b, logic last);
         int unsigned tcp_start;
         int unsigned eth_len;
         int unsigned min_hdr;
         int unsigned ip_len;
         int unsigned tcp_len;
         int unsigned left;
         hdr_result_type r;
         eth_len = int'(ETH_LEN);
         min_hdr = int'(MIN_HDR);
         if (byte_pos < max_bytes) begin
            if (byte_pos < 6)
               dst_mac = {dst_mac[MAC_W-9:0], b};
            else if (byte_pos < 12)
               src_mac = {src_mac[MAC_W-9:0], b};
            else if (byte_pos < eth_len)
               ether_type = {ether_type[ETYPE_W-9:0], b};
            if (byte_pos == eth_len)
               ip_words = b[3:0];
            if (byte_pos >= eth_len + 12 && byte_pos < eth_len + 16)
               src_ip = {src_ip[IP_W-9:0], b};
            if (byte_pos >= eth_len + 16 && byte_pos < eth_len + 20)
               dst_ip = {dst_ip[IP_W-9:0], b};
            tcp_start = eth_len + 4 * int'(ip_words);
            if (byte_pos >= tcp_start && byte_pos < tcp_start + 2)
               sport = {sport[PORT_W-9:0], b};
            if (byte_pos >= tcp_start + 2 && byte_pos < tcp_start + 4)
               dport = {dport[PORT_W-9:0], b};
            if (byte_pos == tcp_start + 12)
               tcp_words = b[7:4];
            byte_pos++;
         end
         if (!last)
            return;

         ip_len  = 4 * int'(ip_words);
         tcp_len = 4 * int'(tcp_words);
         r.payload_length = '0;
         if (byte_pos < eth_len) begin
            r.status = STATUS_ETH_SHORT;
         end else begin
            left = byte_pos - eth_len;
            if (left < min_hdr || left < ip_len) begin
               r.status = STATUS_IP_SHORT;
            end else begin
               left -= ip_len;
               if (left < min_hdr || left < tcp_len) begin
                  r.status = STATUS_TCP_SHORT;
               end else begin
                  r.status = STATUS_OK;
                  r.payload_length = LEN_W'(left - tcp_len);
               end
            end
         end
         r.dst_mac         = dst_mac;
         r.src_mac         = src_mac;
         r.ether_type      = ether_type;
         r.src_ip          = src_ip;
         r.dst_ip          = dst_ip;
         r.sport           = sport;
         r.dport           = dport;
         r.captured_length = LEN_W'(byte_pos);
         pending.insert(pending.size(), r);
         clear();
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 40)
            $display("MISMATCH result %0d: %s", checked, msg);
      endtask

      task compare_field(string name, logic [63:0] got, logic [63:0] want);
         if (got !== want)
            report($sformatf("%s got %0h expected %0h", name, got, want));
      endtask

      task check_result(hdr_result_type got);
         hdr_result_type want;
         if (pending.size() == 0) begin
            report("result with no frame pending");
         end else begin
            want = pending.pop_front();
            compare_field("status", 64'(got.status), 64'(want.status));
            compare_field("dst_mac", 64'(got.dst_mac), 64'(want.dst_mac));
            compare_field("src_mac", 64'(got.src_mac), 64'(want.src_mac));
            compare_field("ether_type", 64'(got.ether_type), 64'(want.ether_type));
            compare_field("src_ip", 64'(got.src_ip), 64'(want.src_ip));
            compare_field("dst_ip", 64'(got.dst_ip), 64'(want.dst_ip));
            compare_field("sport", 64'(got.sport), 64'(want.sport));
            compare_field("dport", 64'(got.dport), 64'(want.dport));
            compare_field("payload_length", 64'(got.payload_length),
                          64'(want.payload_length));
            compare_field("captured_length", 64'(got.captured_length),
                          64'(want.captured_length));
         end
         checked++;
      endtask
   endclass

endpackage

`default_nettype wire

### tb/sv/tb_eth_ipv4_tcp_header_extractor_top.sv
`default_nettype none

module tb_eth_ipv4_tcp_header_extractor_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ethtcp_pkg::*;
   import ethtcp_tb_pkg::*;

   localparam int unsigned MAX_BYTES    = DEFAULT_MAX_FRAME_BYTES;
   localparam int unsigned RANDOM_BYTES = 1000;
   localparam int unsigned MIN_FRAMES   = 10;
   localparam int unsigned IDLE_LIMIT   = 1000;

   logic clock;
   logic reset;

   ethtcp_req_if req_if ();
   ethtcp_rsp_if rsp_if ();

   eth_ipv4_tcp_header_extractor_top #(
      .MAX_FRAME_BYTES(MAX_BYTES)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   frame_scoreboard sb = new(MAX_BYTES);

   logic [BYTE_W-1:0] frame_q[$];
   int unsigned burst_left = 0;
   int unsigned bytes_sent = 0;
   int unsigned frames_sent = 0;
   int unsigned status_seen[4];
   int unsigned idle_cycles = 0;

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      hdr_result_type got;
      if (rsp_if.valid && rsp_if.ready) begin
         got.status          = rsp_if.status;
         got.dst_mac         = rsp_if.dst_mac;
         got.src_mac         = rsp_if.src_mac;
         got.ether_type      = rsp_if.ether_type;
         got.src_ip          = rsp_if.src_ip;
         got.dst_ip          = rsp_if.dst_ip;
         got.sport           = rsp_if.sport;
         got.dport           = rsp_if.dport;
         got.payload_length  = rsp_if.payload_length;
         got.captured_length = rsp_if.captured_length;
         status_seen[rsp_if.status]++;
         sb.check_result(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("tb_eth_ipv4_tcp_header_extractor_top NOT OK");
            $finish;
         end
      end
   end

   initial begin
      int unsigned cycle;
      int unsigned mode;
      int unsigned stall_left;
      cycle = 0;
      mode = 0;
      stall_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         cycle++;
         if (cycle % 300 == 0)
            mode = $urandom_range(0, 2);
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if (mode == 1 && $urandom_range(0, 99) < 15)
               stall_left = $urandom_range(1, 4);
            else if (mode == 2 && $urandom_range(0, 99) < 30)
               stall_left = $urandom_range(1, 40);
         end
      end
   end

   task automatic send_byte(logic [BYTE_W-1:0] b, logic last);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 16);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 64);
      end
      burst_left--;
      req_if.valid      <= 1'b1;
      req_if.frame_byte <= b;
      req_if.last_byte  <= last;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      sb.note_byte(b, last);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame();
      foreach (frame_q[i])
         send_byte(frame_q[i], i == frame_q.size() - 1);
      frames_sent++;
   endtask

   // value below zero: random bytes
   task automatic fill_frame(int unsigned len, int value);
      frame_q.delete();
      repeat (len)
         frame_q.insert(frame_q.size(), (value < 0) ? BYTE_W'($urandom) : BYTE_W'(value));
   endtask

   function automatic int unsigned full_len(int unsigned ihl, int unsigned off);
      return 14 + 4 * ihl + ((4 * off > 20) ? 4 * off : 20);
   endfunction

   task automatic make_frame(int unsigned ihl, int unsigned off, int unsigned len);
      int unsigned tcp_at;
      logic [BYTE_W-1:0] b;
      fill_frame(len, -1);
      tcp_at = 14 + 4 * ihl;
      if (len > 13 && $urandom_range(0, 3) != 0) begin
         frame_q[12] = 8'h08;
         frame_q[13] = 8'h00;
      end
      if (len > 14)
         frame_q[14] = {4'h4, 4'(ihl)};
      if (len > tcp_at + 12) begin
         b = frame_q[tcp_at + 12];
         frame_q[tcp_at + 12] = {4'(off), b[3:0]};
      end
   endtask

   task automatic random_frame();
      int unsigned kind;
      int unsigned ihl;
      int unsigned off;
      int unsigned pay;
      kind = $urandom_range(0, 99);
      ihl  = ($urandom_range(0, 3) != 0) ? 5 : $urandom_range(0, 15);
      off  = ($urandom_range(0, 2) != 0) ? 5 : $urandom_range(0, 15);
      if (kind < 70) begin
         pay = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 24);
         make_frame(ihl, off, full_len(ihl, off) + pay);
      end else if (kind < 85) begin
         make_frame(ihl, off, $urandom_range(1, full_len(ihl, off) - 1));
      end else begin
         fill_frame($urandom_range(1, 80), -1);
      end
   endtask

   initial begin
      int unsigned rand_start;
      int unsigned rand_frames;
      req_if.valid      = 1'b0;
      req_if.frame_byte = '0;
      req_if.last_byte  = 1'b0;
      reset             = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      fill_frame(1, 8'hFF);                 send_frame();
      fill_frame(9, -1);                    send_frame();
      fill_frame(13, 8'h00);                send_frame();
      fill_frame(14, 8'hFF);                send_frame();
      make_frame(5, 5, 33);                 send_frame();
      make_frame(5, 5, 53);                 send_frame();
      make_frame(5, 5, 54);                 send_frame();
      fill_frame(54, 8'hFF);                send_frame();
      fill_frame(54, 8'h00);                send_frame();
      make_frame(15, 15, 14 + 60 + 60 + 10); send_frame();
      make_frame(15, 15, 14 + 60 + 59);     send_frame();
      make_frame(15, 5, 14 + 59);           send_frame();
      make_frame(5, 15, 14 + 20 + 59);      send_frame();
      make_frame(2, 5, 14 + 8 + 20 + 5);    send_frame();
      make_frame(0, 3, full_len(0, 3));     send_frame();
      make_frame(4, 0, full_len(4, 0) + 3); send_frame();
      make_frame(5, 5, 60);                 send_frame();

      rand_start  = bytes_sent;
      rand_frames = 0;
      while (bytes_sent - rand_start < RANDOM_BYTES || rand_frames < MIN_FRAMES) begin
         random_frame();
         send_frame();
         rand_frames++;
      end
      req_if.valid <= 1'b0;

      while (sb.pending.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      $display("%0d frames, %0d bytes sent; %0d results checked", frames_sent, bytes_sent,
               sb.checked);
      $display("status parsed %0d, eth short %0d, ipv4 short %0d, tcp short %0d",
               status_seen[STATUS_OK], status_seen[STATUS_ETH_SHORT],
               status_seen[STATUS_IP_SHORT], status_seen[STATUS_TCP_SHORT]);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("tb_eth_ipv4_tcp_header_extractor_top OK");
      end else begin
         $display("tb_eth_ipv4_tcp_header_extractor_top NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire
